>>> design/esd_pkg.sv
// Shared types for the escape sequence decoder.
// Used by the decode stage, the result queue and the top level; no dependencies.
`default_nettype none

package esd_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;

    // One decoded result as it sits in the output queue.
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               is_end;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

    // Results produced by one accepted byte: n is 0, 1 or 2, r0 goes out first.
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

>>> design/esd_decode.sv
// Per-byte decode stage: escape state machine, byte limit register and count.
// Depends on esd_pkg for the result and push types.
`default_nettype none

module esd_decode
    import esd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [COUNT_W-1:0] cfg_data,
    input  wire logic               in_fire,
    input  wire logic [BYTE_W-1:0]  in_byte,
    output push_t                   push
);

    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_X         = 8'h78;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX_NONE,
        MODE_HEX_ONE
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [3:0]         held_reg, held_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] limit_reg;

    logic               is_hex;
    logic [3:0]         hex_val;
    logic [BYTE_W-1:0]  esc_code;
    logic               is_term;
    logic               want1, want2;
    logic [BYTE_W-1:0]  byte1, byte2;
    logic               emit1, emit2;
    logic [COUNT_W-1:0] cnt1, cnt2;
    result_t            res_a, res_b;
    logic               has_b;

    // Hex digit recognition, either case.
    always_comb
    begin
        is_hex  = 1'b0;
        hex_val = 4'h0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            is_hex  = 1'b1;
            hex_val = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            is_hex  = 1'b1;
            hex_val = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            is_hex  = 1'b1;
            hex_val = 4'(in_byte - 8'h37);
        end
    end

    always_comb
    begin
        case (in_byte)
            8'h6E:   esc_code = 8'h0A;
            8'h72:   esc_code = 8'h0D;
            8'h61:   esc_code = 8'h07;
            8'h74:   esc_code = 8'h09;
            8'h62:   esc_code = 8'h08;
            8'h66:   esc_code = 8'h0C;
            8'h76:   esc_code = 8'h0B;
            default: esc_code = in_byte;
        endcase
    end

    // want1: a flushed 'x' or held digit, always first.
    // want2: the byte the current character decodes to.
    always_comb
    begin
        is_term   = (in_byte == CH_NUL);
        want1     = 1'b0;
        byte1     = CH_X;
        want2     = 1'b0;
        byte2     = in_byte;
        mode_next = mode_reg;
        held_next = held_reg;
        if (is_term)
        begin
            want1     = (mode_reg == MODE_HEX_NONE) || (mode_reg == MODE_HEX_ONE);
            byte1     = (mode_reg == MODE_HEX_ONE) ? {4'h0, held_reg} : CH_X;
            mode_next = MODE_NORMAL;
            held_next = 4'h0;
        end
        else
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    want2     = (in_byte != CH_BACKSLASH);
                    mode_next = (in_byte == CH_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                end
                MODE_ESCAPE:
                begin
                    want2     = (in_byte != CH_X);
                    byte2     = esc_code;
                    mode_next = (in_byte == CH_X) ? MODE_HEX_NONE : MODE_NORMAL;
                end
                MODE_HEX_NONE:
                begin
                    if (is_hex)
                    begin
                        held_next = hex_val;
                        mode_next = MODE_HEX_ONE;
                    end
                    else
                    begin
                        want1     = 1'b1;
                        byte1     = CH_X;
                        want2     = (in_byte != CH_BACKSLASH);
                        mode_next = (in_byte == CH_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                    end
                end
                default:
                begin
                    held_next = 4'h0;
                    if (is_hex)
                    begin
                        want2     = 1'b1;
                        byte2     = {held_reg, hex_val};
                        mode_next = MODE_NORMAL;
                    end
                    else
                    begin
                        want1     = 1'b1;
                        byte1     = {4'h0, held_reg};
                        want2     = (in_byte != CH_BACKSLASH);
                        mode_next = (in_byte == CH_BACKSLASH) ? MODE_ESCAPE : MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    // Byte limit applies to each decoded byte in turn.
    always_comb
    begin
        emit1      = want1 && (count_reg < limit_reg);
        cnt1       = count_reg + COUNT_W'(emit1);
        emit2      = want2 && (cnt1 < limit_reg);
        cnt2       = cnt1 + COUNT_W'(emit2);
        count_next = is_term ? '0 : cnt2;

        has_b        = emit2 || is_term;
        res_b.data   = emit2 ? byte2 : CH_NUL;
        res_b.is_end = !emit2;
        res_b.count  = emit2 ? cnt2 : cnt1;
        res_b.last   = 1'b1;

        res_a.data   = byte1;
        res_a.is_end = 1'b0;
        res_a.count  = cnt1;
        res_a.last   = !has_b;

        if (emit1)
        begin
            push.r0 = res_a;
            push.r1 = res_b;
            push.n  = has_b ? 2'd2 : 2'd1;
        end
        else
        begin
            push.r0 = res_b;
            push.r1 = res_b;
            push.n  = has_b ? 2'd1 : 2'd0;
        end
        if (!in_fire)
        begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            held_reg  <= 4'h0;
            count_reg <= '0;
            limit_reg <= '1;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (in_fire)
            begin
                mode_reg  <= mode_next;
                held_reg  <= held_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/esd_outq.sv
// Result queue: up to two results in, one out a cycle while out_ready.
// Depends on esd_pkg for the result and push types.
`default_nettype none

module esd_outq
    import esd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room2,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    head
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    result_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr_p1;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        out_valid   = (fill_reg != '0);
        head        = mem_reg[rd_ptr_reg];
        room2       = (fill_reg <= FILL_W'(DEPTH - 2));
        pop         = out_valid && out_ready;
        wr_ptr_p1   = ptr_inc(wr_ptr_reg);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.n)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        fill_next = fill_reg + FILL_W'(push.n) - FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

endmodule

`default_nettype wire

>>> design/escape_sequence_decoder.sv
// Top level of the backslash escape decoder.
// Depends on esd_pkg, esd_decode and esd_outq.
//
// Usage:
//   Input channel (in_valid/in_ready/in_byte) carries one source character per
//   request; a zero byte ends the string. Output channel (out_valid/out_ready)
//   carries decoded bytes, and on each terminator an end marker (is_end high,
//   out_byte zero) with the string's byte count in total_count. last_of_run
//   flags the final result caused by one input byte.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the per-string byte
//   limit; cfg_ready is always high. Write it only while the block is idle.
// Output: each result is registered in the result queue before it leaves.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and out_ready is high; a byte yielding two results (flushed hex/x
//   plus a byte, or a flush plus the end marker) sends both out in turn.
//   The result queue of QUEUE_DEPTH entries sets this: in_ready is high while
//   at least two entries are free.
// Reset: decoder returns to normal mode, count cleared, limit set to 65535,
//   result queue emptied.
// Receiver stall: results wait in the queue; once fewer than two entries are
//   free, in_ready drops until the receiver drains it.
`default_nettype none

module escape_sequence_decoder
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BYTE_W-1:0]  in_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [BYTE_W-1:0]       out_byte,
    output logic                    is_end,
    output logic [COUNT_W-1:0]      total_count,
    output logic                    last_of_run
);

    push_t   push;
    result_t head;
    logic    room2;
    logic    in_fire;

    // Config write never stalls; the limit register lives in the decoder.
    assign cfg_ready = 1'b1;

    // A request is only taken when the queue can absorb the worst case of two
    // results, so the decoder never has to hold a byte back.
    assign in_ready = room2;
    assign in_fire  = in_valid && room2;

    esd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_byte   (in_byte),
        .push      (push)
    );

    esd_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Head of queue drives the output fields directly.
    assign out_byte    = head.data;
    assign is_end      = head.is_end;
    assign total_count = head.count;
    assign last_of_run = head.last;

endmodule

`default_nettype wire

>>> design/esd_checker.sv
// Port-level checks for the escape sequence decoder, bound to the top level.
// Depends on esd_pkg for field widths.
`default_nettype none

module esd_checker
    import esd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [BYTE_W-1:0]  in_byte,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [BYTE_W-1:0]  out_byte,
    input wire logic               is_end,
    input wire logic [COUNT_W-1:0] total_count,
    input wire logic               last_of_run
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(is_end) && $stable(total_count) && $stable(last_of_run))
        else $error("stalled result changed");

    // End marker carries a zero byte and closes its run.
    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> out_byte == 8'h00 && last_of_run)
        else $error("malformed end marker");

    // A decoded byte always counts itself.
    a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_end |-> total_count != 16'h0000)
        else $error("decoded byte with zero count");

    // A terminator always leaves a result waiting at the output in the next cycle.
    a_term_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_byte == 8'h00 |=> out_valid)
        else $error("terminator produced no result");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .is_end      (is_end),
    .total_count (total_count),
    .last_of_run (last_of_run)
);

`default_nettype wire

>>> test/escape_decode_checker.sv
// Prediction and checking for the escape sequence decoder testbench.
// Depends on esd_pkg; watches the config, input and output channels of the block.

module escape_decode_checker
    import esd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [BYTE_W-1:0]  out_byte,
    input  logic               is_end,
    input  logic [COUNT_W-1:0] total_count,
    input  logic               last_of_run,
    output int                 mismatches,
    output int                 awaiting,
    output int                 results_checked,
    output int                 ends_checked
);

    typedef enum logic [1:0]
    {
        DEC_PLAIN    = 2'd0,
        DEC_ESCAPE   = 2'd1,
        DEC_HEX_NONE = 2'd2,
        DEC_HEX_ONE  = 2'd3
    } dec_mode_e;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = "x";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LF     = "f";
    localparam logic [7:0] CH_UA     = "A";
    localparam logic [7:0] CH_UF     = "F";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_V      = "v";
    localparam logic [7:0] CODE_BEL  = 8'h07;
    localparam logic [7:0] CODE_BS   = 8'h08;
    localparam logic [7:0] CODE_TAB  = 8'h09;
    localparam logic [7:0] CODE_LF   = 8'h0A;
    localparam logic [7:0] CODE_VT   = 8'h0B;
    localparam logic [7:0] CODE_FF   = 8'h0C;
    localparam logic [7:0] CODE_CR   = 8'h0D;

    dec_mode_e          mode;
    logic [3:0]         held;
    logic [COUNT_W-1:0] emitted;
    logic [COUNT_W-1:0] byte_limit;

    result_t decoded_q[$];
    result_t step_r[2];
    int      step_n;

    int mismatch_count = 0;
    int checked_count  = 0;
    int end_count      = 0;

    assign mismatches      = mismatch_count;
    assign awaiting        = decoded_q.size();
    assign results_checked = checked_count;
    assign ends_checked    = end_count;

    task report_mismatch(input string what);
        $display("%0t decode check: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] val);
        val = 4'h0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            val = 4'(ch - CH_0);
            return 1'b1;
        end
        if (ch >= CH_LA && ch <= CH_LF)
        begin
            val = 4'(ch - (CH_LA - 8'd10));
            return 1'b1;
        end
        if (ch >= CH_UA && ch <= CH_UF)
        begin
            val = 4'(ch - (CH_UA - 8'd10));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] control_code(input logic [7:0] ch);
        case (ch)
            CH_N:    return CODE_LF;
            CH_R:    return CODE_CR;
            CH_LA:   return CODE_BEL;
            CH_T:    return CODE_TAB;
            CH_B:    return CODE_BS;
            CH_LF:   return CODE_FF;
            CH_V:    return CODE_VT;
            default: return ch;
        endcase
    endfunction

    task stage_result(input logic [7:0] data, input logic end_mark);
        result_t r;
        r.data   = data;
        r.is_end = end_mark;
        r.count  = emitted;
        r.last   = 1'b0;
        step_r[step_n] = r;
        step_n++;
    endtask

    // decoded bytes past the limit vanish; decoding itself carries on
    task emit_decoded(input logic [7:0] data);
        if (emitted < byte_limit)
        begin
            emitted = emitted + 1'b1;
            stage_result(data, 1'b0);
        end
    endtask

    task plain_char(input logic [7:0] ch);
        if (ch == CH_BSLASH)
            mode = DEC_ESCAPE;
        else
            emit_decoded(ch);
    endtask

    task decode_char(input logic [7:0] ch);
        logic [3:0] nib;
        step_n = 0;
        if (ch == CH_NUL)
        begin
            if (mode == DEC_HEX_NONE)
                emit_decoded(CH_X);
            else if (mode == DEC_HEX_ONE)
                emit_decoded({4'h0, held});
            stage_result(CH_NUL, 1'b1);
            mode    = DEC_PLAIN;
            held    = 4'h0;
            emitted = '0;
        end
        else
        begin
            case (mode)
                DEC_PLAIN:
                    plain_char(ch);
                DEC_ESCAPE:
                begin
                    mode = DEC_PLAIN;
                    if (ch == CH_X)
                        mode = DEC_HEX_NONE;
                    else
                        emit_decoded(control_code(ch));
                end
                DEC_HEX_NONE:
                begin
                    if (hex_digit(ch, nib))
                    begin
                        held = nib;
                        mode = DEC_HEX_ONE;
                    end
                    else
                    begin
                        mode = DEC_PLAIN;
                        emit_decoded(CH_X);
                        plain_char(ch);
                    end
                end
                default:
                begin
                    mode = DEC_PLAIN;
                    if (hex_digit(ch, nib))
                        emit_decoded({held, nib});
                    else
                    begin
                        emit_decoded({4'h0, held});
                        plain_char(ch);
                    end
                    held = 4'h0;
                end
            endcase
        end
        if (step_n > 0)
            step_r[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            decoded_q.push_back(step_r[i]);
    endtask

    task check_result();
        result_t want;
        if (decoded_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte %02h end %0b count %0d",
                                      out_byte, is_end, total_count));
        end
        else
        begin
            want = decoded_q.pop_front();
            if (out_byte !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
            if (is_end !== want.is_end)
                report_mismatch($sformatf("is_end %0b, want %0b", is_end, want.is_end));
            if (total_count !== want.count)
                report_mismatch($sformatf("total_count %0d, want %0d",
                                          total_count, want.count));
            if (last_of_run !== want.last)
                report_mismatch($sformatf("last_of_run %0b, want %0b",
                                          last_of_run, want.last));
            checked_count++;
            if (want.is_end)
                end_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode       = DEC_PLAIN;
            held       = 4'h0;
            emitted    = '0;
            byte_limit = 16'hFFFF;
            decoded_q.delete();
        end
        else
        begin
            // results leave through the block's registered result queue, so the
            // queue head is always older than anything accepted at this edge
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
                byte_limit = cfg_data;
            if (in_valid && in_ready)
                decode_char(in_byte);
        end
    end

endmodule

>>> test/escape_sequence_decoder_tb.sv
// Testbench top for the escape sequence decoder: clock, reset, stimulus and verdict.
// Depends on esd_pkg, escape_sequence_decoder and escape_decode_checker.

module escape_sequence_decoder_tb;

    import esd_pkg::*;

    // Generous ceiling: ~600 requests, each worst case two results behind
    // receiver stalls plus a sender gap, plus the long hold-off.
    localparam int RUN_LIMIT    = 300000;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = "x";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_UA     = "A";

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic [BYTE_W-1:0]  in_byte   = '0;
    logic               out_ready = 1'b0;

    wire                cfg_ready;
    wire                in_ready;
    wire                out_valid;
    wire [BYTE_W-1:0]   out_byte;
    wire                is_end;
    wire [COUNT_W-1:0]  total_count;
    wire                last_of_run;

    int mismatches;
    int awaiting;
    int results_checked;
    int ends_checked;

    int chars_sent   = 0;
    int strings_sent = 0;
    int limit_writes = 0;
    int cycle_count  = 0;

    // quiet: no idling on either side; hold_req: receiver to back off for a
    // long stretch (cleared by the receiver once done)
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    // escape letters with a control code, and bytes just either side of the
    // hex digit ranges
    string esc_letters = "nratbfv";
    string hex_edges   = "/:@Gg";

    escape_sequence_decoder DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_end      (is_end),
        .total_count (total_count),
        .last_of_run (last_of_run)
    );

    escape_decode_checker decode_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .is_end          (is_end),
        .total_count     (total_count),
        .last_of_run     (last_of_run),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .ends_checked    (ends_checked)
    );

    always #1 clk = ~clk;

    // Cycle ceiling; only reached if the block hangs or drops results.
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("escape_sequence_decoder_tb: cycle limit of %0d hit", RUN_LIMIT);
        $display("escape_sequence_decoder_tb: done, errors");
        $finish;
    end

    // Receiver. Every change of out_ready lands on a falling edge, one
    // assignment per edge. Normally random ready/stall bursts; on request a
    // single long hold-off so the result queue fills and in_ready drops.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (quiet)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 19)) @(negedge clk);
            end
        end
    end

    // One request on the input channel. Entered and left at a falling edge.
    // An optional gap comes first, so valid is never dropped and raised at
    // the same edge. in_ready is sampled at the rising edge, before the
    // block's own updates land.
    task automatic send_char(input logic [7:0] ch);
        if (!quiet && !hold_req && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        chars_sent++;
        if (ch == CH_NUL)
            strings_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Wait until every predicted result has come back, then give the block
    // time to settle for requests that produce nothing.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Limit writes only with the block idle; a string may still be open.
    task automatic write_limit(input logic [COUNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [7:0] hex_char();
        case ($urandom_range(0, 2))
            0:       return CH_0 + 8'($urandom_range(0, 9));
            1:       return CH_LA + 8'($urandom_range(0, 5));
            default: return CH_UA + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // One lexical piece of a source string: escapes with random content, raw
    // bytes, hex digits, bytes beside the hex ranges, and lone backslashes as noise.
    task automatic send_token();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:
                send_char(8'($urandom_range(1, 255)));
            2:
                send_char(8'($urandom_range(8'h20, 8'h7E)));
            3:
            begin
                send_char(CH_BSLASH);
                if ($urandom_range(0, 2) == 0)
                    send_char(8'($urandom_range(1, 255)));
                else
                    send_char(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
            end
            4:
            begin
                send_char(CH_BSLASH);
                send_char(CH_BSLASH);
            end
            5, 6:
            begin
                // \x with none, one or two digits; whatever follows decides
                send_char(CH_BSLASH);
                send_char(CH_X);
                repeat ($urandom_range(0, 2)) send_char(hex_char());
            end
            7:
                send_char(CH_BSLASH);
            8:
                send_char(hex_edges[$urandom_range(0, hex_edges.len() - 1)]);
            default:
                send_char(hex_char());
        endcase
    endtask

    task automatic send_string();
        repeat ($urandom_range(0, 10)) send_token();
        send_char(CH_NUL);
    endtask

    initial
    begin
        int phase_end;
        logic [COUNT_W-1:0] lim;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- Directed part, limit at its reset value ----
        // byte extremes, then double backslash, every control escape and an
        // unknown escape letter that passes through
        send_char(8'h01);
        send_char(8'hFF);
        send_text("\\\\\\n\\r\\a\\t\\b\\f\\v\\q");
        // two mixed-case digits; one digit then a non-hex byte; \x then a
        // non-hex byte; \x then a backslash that opens a fresh escape
        send_text("\\xFf\\x7g\\xq\\x\\n");
        send_char(CH_NUL);
        // terminator right after \x, after one held digit, after a lone
        // backslash
        send_text("\\x");
        send_char(CH_NUL);
        send_text("\\x5");
        send_char(CH_NUL);
        send_char(CH_BSLASH);
        send_char(CH_NUL);

        // limit of zero: end markers only
        write_limit(16'd0);
        send_text("ab");
        send_char(CH_NUL);
        // limit reached: later bytes dropped, decoding carries on
        write_limit(16'd2);
        send_text("ab\\x41c");
        send_char(CH_NUL);
        // limit lowered below the count part way through a string
        write_limit(16'hFFFF);
        send_text("abc");
        write_limit(16'd1);
        send_text("d");
        send_char(CH_NUL);

        // ---- Random part, one limit setting per phase ----
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       lim = 16'($urandom_range(2, 6));
                1:       lim = 16'hFFFF;
                2:       lim = 16'd0;
                3:       lim = 16'd1;
                4:       lim = 16'($urandom_range(3, 12));
                default: lim = 16'($urandom_range(5, 40));
            endcase
            write_limit(lim);
            if (p == 0)
                hold_req = 1'b1;
            if (p == PHASES - 1)
                quiet = 1'b1;
            phase_end = chars_sent + RANDOM_ITEMS / PHASES;
            while (chars_sent < phase_end)
                send_string();
        end

        drain();

        $display("escape_sequence_decoder_tb: %0d bytes in %0d strings, %0d limit settings",
                 chars_sent, strings_sent, limit_writes);
        $display("escape_sequence_decoder_tb: %0d results checked, %0d end markers",
                 results_checked, ends_checked);
        if (mismatches == 0)
            $display("escape_sequence_decoder_tb: done, clean");
        else
            $display("escape_sequence_decoder_tb: done, errors");
        $finish;
    end

endmodule
